FILE: hdl/rrbm_pkg.sv
// Shared types and constants for the ROM/RAM bank mapper.
`default_nettype none

package rrbm_pkg;

   // Banked cartridge RAM: four banks of 8 KiB.
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned RAM_BANKS      = 4;
   localparam int unsigned RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
   localparam int unsigned RAM_ADDR_W     = $clog2(RAM_DEPTH);
   localparam int unsigned RAM_OFFS_W     = $clog2(RAM_BANK_BYTES);

   // ROM banking: 16 KiB banks, at most 128 of them.
   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned ROM_OFFS_W     = $clog2(ROM_BANK_BYTES);
   localparam int unsigned ROM_BANK_W     = 7;
   localparam int unsigned MAX_ROM_BANKS  = 128;
   localparam int unsigned MIN_ROM_BANKS  = 2;

   // Bus access kinds.
   typedef enum logic [1:0] {
      OP_ROM_READ   = 2'd0,
      OP_CTRL_WRITE = 2'd1,
      OP_RAM_READ   = 2'd2,
      OP_RAM_WRITE  = 2'd3
   } opcode_type;

   // Control register regions, decoded from address bits 15:13.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
   localparam logic [2:0] REGION_RAM_BANK   = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;

   // Low nibble that turns RAM enable on.
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ROM_BANK_COUNT = 2'd0;
   localparam logic [1:0] CSR_ROM_SIZE_CODE  = 2'd1;
   localparam logic [1:0] CSR_RAM_SIZE_CODE  = 2'd2;

   // Header size codes above these allow the banking mode to be set.
   localparam logic [3:0] ROM_SIZE_MODE_MIN = 4'd4;
   localparam logic [2:0] RAM_SIZE_MODE_MIN = 3'd2;

   // Request to the banked RAM: one address shared by read and write.
   typedef struct packed {
      logic                  we;
      logic [RAM_ADDR_W-1:0] addr;
      logic [7:0]            wdata;
   } ram_req_type;

   // Configuration as the datapath sees it.
   typedef struct packed {
      logic [7:0] bank_count;
      logic       mode_ok;
   } cfg_type;

   // Start request for the remainder unit.
   typedef struct packed {
      logic                  start;
      logic [ROM_BANK_W-1:0] dividend;
      logic [7:0]            divisor;
   } div_req_type;

endpackage

`default_nettype wire

FILE: hdl/rrbm_csr.sv
// Configuration registers of the bank mapper behind an APB-style port.
`default_nettype none

module rrbm_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [3:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output rrbm_pkg::cfg_type    cfg
);

   logic [7:0] rom_bank_count_ff;
   logic [3:0] rom_size_code_ff;
   logic [2:0] ram_size_code_ff;
   logic [1:0] reg_idx;
   logic       wr_beat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_beat = psel && penable && pwrite;

   // Register writes on the access beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_count_ff <= 8'd2;
         rom_size_code_ff  <= 4'd0;
         ram_size_code_ff  <= 3'd0;
      end else if (wr_beat) begin
         unique case (reg_idx)
            rrbm_pkg::CSR_ROM_BANK_COUNT: rom_bank_count_ff <= pwdata[7:0];
            rrbm_pkg::CSR_ROM_SIZE_CODE:  rom_size_code_ff  <= pwdata[3:0];
            rrbm_pkg::CSR_RAM_SIZE_CODE:  ram_size_code_ff  <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_idx)
         rrbm_pkg::CSR_ROM_BANK_COUNT: prdata = {24'd0, rom_bank_count_ff};
         rrbm_pkg::CSR_ROM_SIZE_CODE:  prdata = {28'd0, rom_size_code_ff};
         rrbm_pkg::CSR_RAM_SIZE_CODE:  prdata = {29'd0, ram_size_code_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // Bank count clamped to the supported range; mode permission from the header codes.
   always_comb begin
      priority if (rom_bank_count_ff < 8'(rrbm_pkg::MIN_ROM_BANKS)) begin
         cfg.bank_count = 8'(rrbm_pkg::MIN_ROM_BANKS);
      end else if (rom_bank_count_ff > 8'(rrbm_pkg::MAX_ROM_BANKS)) begin
         cfg.bank_count = 8'(rrbm_pkg::MAX_ROM_BANKS);
      end else begin
         cfg.bank_count = rom_bank_count_ff;
      end
      cfg.mode_ok = (ram_size_code_ff > rrbm_pkg::RAM_SIZE_MODE_MIN)
                 && (rom_size_code_ff > rrbm_pkg::ROM_SIZE_MODE_MIN);
   end

endmodule

`default_nettype wire

FILE: hdl/rrbm_mod_unit.sv
// Bit-serial remainder unit: reduces a ROM bank number modulo the bank count.
`default_nettype none

module rrbm_mod_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rrbm_pkg::div_req_type                 req,
   output logic                                       done,
   output logic [rrbm_pkg::ROM_BANK_W-1:0]            remainder
);

   localparam int unsigned BW = rrbm_pkg::ROM_BANK_W;

   logic [BW-1:0]          rem_ff, rem_in;
   logic [BW-1:0]          dvd_ff, dvd_in;
   logic [7:0]             dsr_ff, dsr_in;
   logic [$clog2(BW+1)-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [7:0]             trial;

   assign done      = done_ff;
   assign remainder = rem_ff;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   // The partial remainder stays below the divisor, so it fits in BW bits.
   always_comb begin
      trial   = {rem_ff, dvd_ff[BW-1]};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = ($clog2(BW+1))'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= dsr_ff) begin
            rem_in = BW'(trial - dsr_ff);
         end else begin
            rem_in = BW'(trial);
         end
         dvd_in = {dvd_ff[BW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(BW+1))'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

endmodule

`default_nettype wire

FILE: hdl/rrbm_ram.sv
// Banked cartridge RAM with a clearing pass after reset.
`default_nettype none

module rrbm_ram (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rrbm_pkg::ram_req_type            req,
   output logic [7:0]                            rd_data,
   output logic                                  clear_busy
);

   localparam int unsigned AW = rrbm_pkg::RAM_ADDR_W;

   logic [7:0]    mem [rrbm_pkg::RAM_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW:0]   clr_cnt_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // The counter's top bit marks the end of the clearing pass.
   assign clear_busy = !clr_cnt_ff[AW];
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clear_busy) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Write port: clearing sweep first, then the datapath.
   always_comb begin
      if (clear_busy) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff[AW-1:0];
         mem_wdata = 8'd0;
      end else begin
         mem_we    = req.we;
         mem_waddr = req.addr;
         mem_wdata = req.wdata;
      end
   end

   // Storage with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[req.addr];
   end

endmodule

`default_nettype wire

FILE: hdl/rom_ram_bank_mapper_core.sv
// Top level of the cartridge ROM/RAM bank mapper: sequencer, bank registers, result stage.
//
// Each request beat is one bus access and gives exactly one response beat. After reset
// the 32 KiB banked RAM is swept to zero, one byte per cycle; req_stall stays high until
// the sweep ends, while configuration writes are taken at once. Control and RAM writes go
// straight to the commit state; a RAM read passes the RAM read state for the registered
// RAM read; a ROM read waits in the divide state for the bit-serial remainder unit, which
// reduces the bank number modulo the bank count one bit per cycle. One access is in work
// at a time; a new one may be taken while the previous response still waits in the output
// register. Configuration may be written only while the block is idle.
`default_nettype none

module rom_ram_bank_mapper_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_value,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_rom_address,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_ram_enable_flag,
   // Configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned BW = rrbm_pkg::ROM_BANK_W;
   localparam int unsigned OW = rrbm_pkg::ROM_OFFS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RAM_READ,
      ST_COMMIT
   } state_type;

   rrbm_pkg::cfg_type     cfg;
   rrbm_pkg::ram_req_type ram_req;
   rrbm_pkg::div_req_type div_req;
   rrbm_pkg::opcode_type  op;
   logic [7:0]            ram_rd_data;
   logic                  clear_busy;
   logic                  div_done;
   logic [BW-1:0]         div_rem;

   state_type   state_ff, state_in;
   logic        bank_mode_ff, bank_mode_in;
   logic [BW-1:0] rom_bank_ff, rom_bank_in;
   logic [1:0]  ram_bank_ff, ram_bank_in;
   logic [1:0]  upper_bits_ff, upper_bits_in;
   logic        ram_enable_ff, ram_enable_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic [20:0] res_rom_ff, res_rom_in;
   logic [7:0]  res_data_ff, res_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [20:0] rsp_rom_ff, rsp_rom_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_en_ff, rsp_en_in;
   logic        accept;
   logic [4:0]  bank_low;
   logic [BW-1:0] rom_sel_bank;

   rrbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rrbm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   rrbm_ram u_ram (
      .clock      (clock),
      .reset      (reset),
      .req        (ram_req),
      .rd_data    (ram_rd_data),
      .clear_busy (clear_busy)
   );

   assign op        = rrbm_pkg::opcode_type'(req_opcode);
   assign req_stall = (state_ff != ST_IDLE) || clear_busy;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rom_address     = rsp_rom_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_ram_enable_flag = rsp_en_ff;

   // The fixed window uses the upper bits only in mode 1; the switched window uses rom_bank.
   always_comb begin
      if (req_address[15:OW] == '0) begin
         rom_sel_bank = bank_mode_ff ? {upper_bits_ff, 5'd0} : '0;
      end else begin
         rom_sel_bank = rom_bank_ff;
      end
   end

   assign bank_low = (req_value[4:0] == 5'd0) ? 5'd1 : req_value[4:0];

   // RAM and remainder requests are issued on the accept beat.
   always_comb begin
      ram_req.we    = accept && (op == rrbm_pkg::OP_RAM_WRITE);
      ram_req.addr  = {ram_bank_ff, req_address[rrbm_pkg::RAM_OFFS_W-1:0]};
      ram_req.wdata = req_value;
      div_req.start    = accept && (op == rrbm_pkg::OP_ROM_READ);
      div_req.dividend = rom_sel_bank;
      div_req.divisor  = cfg.bank_count;
   end

   // Sequencer, bank registers and result stage.
   always_comb begin
      state_in      = state_ff;
      bank_mode_in  = bank_mode_ff;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      upper_bits_in = upper_bits_ff;
      ram_enable_in = ram_enable_ff;
      offset_in     = offset_ff;
      res_rom_in    = res_rom_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rom_in    = rsp_rom_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_en_in     = rsp_en_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_rom_in  = '0;
               res_data_in = '0;
               offset_in   = req_address[OW-1:0];
               unique case (op)
                  rrbm_pkg::OP_ROM_READ:  state_in = ST_DIVIDE;
                  rrbm_pkg::OP_RAM_READ:  state_in = ST_RAM_READ;
                  rrbm_pkg::OP_RAM_WRITE: state_in = ST_COMMIT;
                  rrbm_pkg::OP_CTRL_WRITE: begin
                     state_in = ST_COMMIT;
                     if (req_address[15] == 1'b0) begin
                        unique case (req_address[14:13])
                           rrbm_pkg::REGION_RAM_ENABLE[1:0]: begin
                              ram_enable_in = (req_value[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
                           end
                           rrbm_pkg::REGION_ROM_BANK[1:0]: begin
                              rom_bank_in = bank_mode_ff ? {upper_bits_ff, bank_low}
                                                         : {2'd0, bank_low};
                           end
                           rrbm_pkg::REGION_RAM_BANK[1:0]: begin
                              ram_bank_in   = req_value[1:0];
                              upper_bits_in = req_value[1:0];
                           end
                           rrbm_pkg::REGION_MODE[1:0]: begin
                              if (cfg.mode_ok) begin
                                 bank_mode_in = req_value[0];
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_rom_in = {div_rem, offset_ff};
               state_in   = ST_COMMIT;
            end
         end
         ST_RAM_READ: begin
            res_data_in = ram_rd_data;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Load the output register once its previous beat has gone.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rom_in   = res_rom_ff;
               rsp_data_in  = res_data_ff;
               rsp_en_in    = ram_enable_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_mode_ff  <= 1'b0;
         rom_bank_ff   <= BW'(1);
         ram_bank_ff   <= 2'd0;
         upper_bits_ff <= 2'd0;
         ram_enable_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_mode_ff  <= bank_mode_in;
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         upper_bits_ff <= upper_bits_in;
         ram_enable_ff <= ram_enable_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      offset_ff   <= offset_in;
      res_rom_ff  <= res_rom_in;
      res_data_ff <= res_data_in;
      rsp_rom_ff  <= rsp_rom_in;
      rsp_data_ff <= rsp_data_in;
      rsp_en_ff   <= rsp_en_in;
   end

endmodule

`default_nettype wire
